/* src/keyed_slot_directory_lookup_defines.svh */
// Assertion macros shared by the keyed slot directory lookup RTL.
// Depends on nothing; each macro expects a clk and an rst signal in scope.
`ifndef KEYED_SLOT_DIRECTORY_LOOKUP_DEFINES_SVH
`define KEYED_SLOT_DIRECTORY_LOOKUP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define KSDL_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define KSDL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* src/ksdl_pkg.sv */
// Types and constants for the keyed slot directory lookup.
// Used by the top level; depends on nothing.
package ksdl_pkg;

  typedef enum logic [1:0] {
    OP_WRITE    = 2'd0,
    OP_ERASE    = 2'd1,
    OP_SELECT   = 2'd2,
    OP_RESELECT = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_SLOT = 2'd1,
    ST_TOO_LONG = 2'd2
  } status_t;

  localparam logic [15:0] CAPACITY_RESET = 16'd8144;

  typedef struct packed {
    opcode_t     opcode;
    logic [7:0]  slot_index;
    logic [15:0] vendor_id;
    logic [15:0] product_id;
    logic [31:0] content_hash;
    logic [15:0] payload_length;
  } req_t;

  typedef struct packed {
    status_t    status;
    logic       slot_found;
    logic [3:0] active_index;
    logic       active_changed;
    logic [4:0] used_count;
  } rsp_t;

  typedef struct packed {
    logic [15:0] vendor;
    logic [15:0] product;
    logic [31:0] hash;
  } entry_t;

endpackage

/* src/ksdl_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// Standalone; used for the slot header store.
module ksdl_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* src/keyed_slot_directory_lookup.sv */
// Top level of the keyed slot directory lookup: slot store, scan sequencer, result register.
// Depends on ksdl_pkg, ksdl_ram and keyed_slot_directory_lookup_defines.svh.
//
//   channel   direction  handshake            payload
//   in        request    in_valid / in_ready   req_t
//   out       result     out_valid / out_ready rsp_t
//   cfg       write      cfg_we                cfg_wdata (data capacity)
//
// Write and erase requests are answered straight away: their result is loaded as they are taken.
// A select or reselect scans the slots one per cycle through the RAM read port, stopping
// early on an exact hash match; a key with zero vendor and product ids skips the scan.
// A request is taken only while the sequencer is idle and the result register is free
// or being emptied. Reset clears all valid marks at once; no clearing pass is needed.
`include "keyed_slot_directory_lookup_defines.svh"

module keyed_slot_directory_lookup
  import ksdl_pkg::*;
#(
  parameter int SLOT_COUNT = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  req_t        in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output rsp_t        out_data,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);

  localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int CNT_W = $clog2(SLOT_COUNT + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } state_t;

  state_t                 state;
  logic [15:0]            capacity;
  logic [SLOT_COUNT-1:0]  valid;
  logic [SLOT_COUNT-1:0]  valid_next;
  logic [CNT_W-1:0]       used;
  logic [CNT_W-1:0]       used_next;
  logic                   active_valid;
  logic [IDX_W-1:0]       current_slot;
  logic [15:0]            saved_vendor;
  logic [15:0]            saved_product;
  logic [31:0]            saved_hash;
  logic [CNT_W-1:0]       issue_cnt;
  logic                   cmp_live;
  logic [IDX_W-1:0]       cmp_idx;
  logic                   sel_hit;
  logic [IDX_W-1:0]       sel_idx;

  logic                   accept;
  logic                   slot_ok;
  logic                   len_ok;
  logic [IDX_W-1:0]       slot_sel;
  logic                   wr_ok;
  logic                   er_ok;
  status_t                req_status;
  entry_t                 entry_in;
  entry_t                 entry_rd;
  logic                   cmp_hit;
  logic                   cmp_strict;
  logic                   cmp_last;
  logic                   sel_changed;
  logic                   out_free;
  logic                   out_load;
  logic [7:0]             active_ext;
  logic [7:0]             sel_ext;
  logic [7:0]             used_ext;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE) && out_free;
  assign accept   = in_valid && in_ready;
  assign out_load = (accept && ((in_data.opcode == OP_WRITE) || (in_data.opcode == OP_ERASE)))
                    || ((state == S_FINISH) && out_free);

  always_comb begin
    slot_ok    = {1'b0, in_data.slot_index} < 9'(SLOT_COUNT);
    len_ok     = in_data.payload_length <= capacity;
    slot_sel   = in_data.slot_index[IDX_W-1:0];
    wr_ok      = accept && (in_data.opcode == OP_WRITE) && slot_ok && len_ok;
    er_ok      = accept && (in_data.opcode == OP_ERASE) && slot_ok;
    valid_next = valid;
    used_next  = used;
    if (wr_ok) begin
      valid_next[slot_sel] = 1'b1;
      if (!valid[slot_sel]) begin
        used_next = CNT_W'(used + 1'b1);
      end
    end
    if (er_ok) begin
      valid_next[slot_sel] = 1'b0;
      if (valid[slot_sel]) begin
        used_next = CNT_W'(used - 1'b1);
      end
    end
    if (!slot_ok) begin
      req_status = ST_BAD_SLOT;
    end else if ((in_data.opcode == OP_WRITE) && !len_ok) begin
      req_status = ST_TOO_LONG;
    end else begin
      req_status = ST_OK;
    end
  end

  assign entry_in.vendor  = in_data.vendor_id;
  assign entry_in.product = in_data.product_id;
  assign entry_in.hash    = in_data.content_hash;

  ksdl_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (SLOT_COUNT)
  ) u_store (
    .clk   (clk),
    .we    (wr_ok),
    .waddr (slot_sel),
    .wdata (entry_in),
    .raddr (issue_cnt[IDX_W-1:0]),
    .rdata (entry_rd)
  );

  always_comb begin
    cmp_hit     = cmp_live && valid[cmp_idx] && (entry_rd.vendor == saved_vendor)
                  && (entry_rd.product == saved_product);
    cmp_strict  = cmp_hit && (saved_hash != 32'd0) && (entry_rd.hash == saved_hash);
    cmp_last    = cmp_idx == IDX_W'(SLOT_COUNT - 1);
    sel_changed = !((sel_hit == active_valid) && (!sel_hit || (sel_idx == current_slot)));
    active_ext  = 8'(current_slot);
    sel_ext     = 8'(sel_idx);
    used_ext    = 8'(used_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      capacity      <= CAPACITY_RESET;
      valid         <= '0;
      used          <= '0;
      active_valid  <= 1'b0;
      current_slot  <= '0;
      saved_vendor  <= '0;
      saved_product <= '0;
      saved_hash    <= '0;
      issue_cnt     <= '0;
      cmp_live      <= 1'b0;
      sel_hit       <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_we) begin
        capacity <= cfg_wdata;
      end
      valid <= valid_next;
      used  <= used_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            issue_cnt <= '0;
            cmp_live  <= 1'b0;
            sel_hit   <= 1'b0;
            case (in_data.opcode)
              OP_WRITE, OP_ERASE: begin
                out_data.status         <= req_status;
                out_data.slot_found     <= active_valid;
                out_data.active_index   <= active_valid ? active_ext[3:0] : 4'd0;
                out_data.active_changed <= 1'b0;
                out_data.used_count     <= used_ext[4:0];
              end
              OP_SELECT: begin
                saved_vendor  <= in_data.vendor_id;
                saved_product <= in_data.product_id;
                saved_hash    <= in_data.content_hash;
                if ((in_data.vendor_id == 16'd0) && (in_data.product_id == 16'd0)) begin
                  state <= S_FINISH;
                end else begin
                  state <= S_SCAN;
                end
              end
              default: begin
                active_valid <= 1'b0;
                current_slot <= '0;
                if ((saved_vendor == 16'd0) && (saved_product == 16'd0)) begin
                  state <= S_FINISH;
                end else begin
                  state <= S_SCAN;
                end
              end
            endcase
          end
        end
        S_SCAN: begin
          if (issue_cnt < CNT_W'(SLOT_COUNT)) begin
            issue_cnt <= CNT_W'(issue_cnt + 1'b1);
          end
          cmp_live <= issue_cnt < CNT_W'(SLOT_COUNT);
          cmp_idx  <= issue_cnt[IDX_W-1:0];
          if (cmp_strict) begin
            sel_hit <= 1'b1;
            sel_idx <= cmp_idx;
            state   <= S_FINISH;
          end else begin
            if (cmp_hit && !sel_hit) begin
              sel_hit <= 1'b1;
              sel_idx <= cmp_idx;
            end
            if (cmp_live && cmp_last) begin
              state <= S_FINISH;
            end
          end
        end
        S_FINISH: begin
          if (out_free) begin
            out_data.status         <= ST_OK;
            out_data.slot_found     <= sel_hit;
            out_data.active_index   <= sel_hit ? sel_ext[3:0] : 4'd0;
            out_data.active_changed <= sel_changed;
            out_data.used_count     <= used_ext[4:0];
            active_valid            <= sel_hit;
            current_slot            <= sel_hit ? sel_idx : '0;
            state                   <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `KSDL_ASSERT_NOW(a_used_matches_valid, 1'b1, used == CNT_W'($countones(valid)),
    "used count disagrees with the valid marks")
  `KSDL_ASSERT_NOW(a_active_in_range, active_valid,
    active_ext < 8'(SLOT_COUNT), "active slot beyond the directory")
  `KSDL_ASSERT_NEXT(a_select_blocks, accept && ((in_data.opcode == OP_SELECT)
    || (in_data.opcode == OP_RESELECT)), !in_ready, "request taken during a select")
  `KSDL_ASSERT_NOW(a_scan_keeps_valid, state == S_SCAN, valid_next == valid,
    "valid marks changed during a scan")

endmodule

/* test/ksdl_directory_check_pkg.sv */
`timescale 1ns / 100ps
// Scoreboard for the keyed slot directory lookup: predicts each result and checks it.
// Depends on ksdl_pkg for the request, result and entry types.
package ksdl_directory_check_pkg;
  import ksdl_pkg::*;

  localparam int DIRECTORY_SLOTS = 16;

  class directory_scoreboard;
    logic [15:0] capacity;
    bit          slot_used [DIRECTORY_SLOTS];
    entry_t      slot_entry [DIRECTORY_SLOTS];
    bit          active_found;
    int          current_slot;
    entry_t      saved_key;
    rsp_t        expected_q [$];
    int          mismatches;
    int          results_seen;

    function new();
      capacity = CAPACITY_RESET;
      foreach (slot_used[i]) begin
        slot_used[i] = 1'b0;
        slot_entry[i] = '0;
      end
      active_found = 1'b0;
      current_slot = 0;
      saved_key = '0;
      mismatches = 0;
      results_seen = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // An exact hash match wins; otherwise the lowest slot with matching ids.
    function bit select_with(entry_t key);
      bit hit;
      bit exact;
      int where;
      hit = 1'b0;
      exact = 1'b0;
      where = 0;
      saved_key = key;
      if (key.vendor != 16'd0 || key.product != 16'd0) begin
        for (int i = 0; i < DIRECTORY_SLOTS; i++) begin
          if (!exact && slot_used[i] && slot_entry[i].vendor == key.vendor &&
              slot_entry[i].product == key.product) begin
            if (key.hash != 32'd0 && slot_entry[i].hash == key.hash) begin
              exact = 1'b1;
              hit = 1'b1;
              where = i;
            end else if (!hit) begin
              hit = 1'b1;
              where = i;
            end
          end
        end
      end
      if (hit == active_found && (!hit || where == current_slot)) return 1'b0;
      active_found = hit;
      current_slot = hit ? where : 0;
      return 1'b1;
    endfunction

    function void note_request(req_t r);
      rsp_t   e;
      entry_t key;
      int     used;
      e = '0;
      e.status = ST_OK;
      used = 0;
      key.vendor = r.vendor_id;
      key.product = r.product_id;
      key.hash = r.content_hash;
      case (r.opcode)
        OP_WRITE: begin
          if (r.slot_index >= DIRECTORY_SLOTS) e.status = ST_BAD_SLOT;
          else if (r.payload_length > capacity) e.status = ST_TOO_LONG;
          else begin
            slot_used[r.slot_index] = 1'b1;
            slot_entry[r.slot_index] = key;
          end
        end
        OP_ERASE: begin
          if (r.slot_index >= DIRECTORY_SLOTS) e.status = ST_BAD_SLOT;
          else slot_used[r.slot_index] = 1'b0;
        end
        OP_SELECT: begin
          e.active_changed = select_with(key);
        end
        default: begin
          active_found = 1'b0;
          current_slot = 0;
          e.active_changed = select_with(saved_key);
        end
      endcase
      foreach (slot_used[i]) if (slot_used[i]) used++;
      e.slot_found = active_found;
      e.active_index = active_found ? 4'(current_slot) : 4'd0;
      e.used_count = 5'(used);
      expected_q.push_back(e);
    endfunction

    task report(string msg);
      if (mismatches < 100) $display("%0t: result %0d: %s", $time, results_seen, msg);
      mismatches++;
    endtask

    task check_result(rsp_t got);
      rsp_t e;
      results_seen++;
      if (expected_q.size() == 0) begin
        report($sformatf("no request pending for result %h", got));
      end else begin
        e = expected_q.pop_front();
        if (got.status != e.status)
          report($sformatf("status %0d, expected %0d", got.status, e.status));
        if (got.slot_found != e.slot_found)
          report($sformatf("slot_found %0d, expected %0d", got.slot_found, e.slot_found));
        if (got.active_index != e.active_index)
          report($sformatf("active_index %0d, expected %0d", got.active_index,
                           e.active_index));
        if (got.active_changed != e.active_changed)
          report($sformatf("active_changed %0d, expected %0d", got.active_changed,
                           e.active_changed));
        if (got.used_count != e.used_count)
          report($sformatf("used_count %0d, expected %0d", got.used_count, e.used_count));
      end
    endtask
  endclass

endpackage

/* test/keyed_slot_directory_lookup_test.sv */
`timescale 1ns / 100ps
// Top-level testbench of the keyed slot directory lookup: directed and random requests,
// random stalls on both channels. Depends on ksdl_pkg and ksdl_directory_check_pkg.
module keyed_slot_directory_lookup_test;
  import ksdl_pkg::*;
  import ksdl_directory_check_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_REQUESTS = 75;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  req_t        in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  rsp_t        out_data;
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_wdata = 16'd0;

  directory_scoreboard board;
  int          receiver_hold = 0;
  int          sender_calm = 0;
  logic [15:0] pool_vendor [4];
  logic [15:0] pool_product [4];
  logic [31:0] pool_hash [4];

  keyed_slot_directory_lookup #(
    .SLOT_COUNT(DIRECTORY_SLOTS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int idle_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  function automatic req_t build_request(opcode_t op, int slot, logic [15:0] v,
                                         logic [15:0] p, logic [31:0] h,
                                         logic [15:0] len);
    req_t r;
    r.opcode = op;
    r.slot_index = 8'(slot);
    r.vendor_id = v;
    r.product_id = p;
    r.content_hash = h;
    r.payload_length = len;
    return r;
  endfunction

  function automatic req_t random_request();
    req_t r;
    int   pick;
    int   k;
    int   cap;
    cap = board.capacity;
    k = $urandom_range(0, 3);
    pick = $urandom_range(0, 99);
    if (pick < 40) r.opcode = OP_WRITE;
    else if (pick < 55) r.opcode = OP_ERASE;
    else if (pick < 85) r.opcode = OP_SELECT;
    else r.opcode = OP_RESELECT;
    if ($urandom_range(0, 9) == 0) r.slot_index = 8'($urandom_range(16, 255));
    else r.slot_index = 8'($urandom_range(0, DIRECTORY_SLOTS - 1));
    pick = $urandom_range(0, 19);
    if (pick == 0) begin
      r.vendor_id = 16'd0;
      r.product_id = 16'd0;
    end else if (pick < 3) begin
      r.vendor_id = 16'($urandom);
      r.product_id = 16'($urandom);
    end else begin
      r.vendor_id = pool_vendor[k];
      r.product_id = pool_product[k];
    end
    pick = $urandom_range(0, 19);
    if (pick < 4) r.content_hash = 32'd0;
    else if (pick < 16) r.content_hash = pool_hash[$urandom_range(0, 3)];
    else r.content_hash = $urandom;
    pick = $urandom_range(0, 9);
    if (pick < 7) r.payload_length = 16'($urandom_range(0, cap));
    else if (pick < 9 && cap < 65535) r.payload_length = 16'($urandom_range(cap + 1, 65535));
    else r.payload_length = 16'($urandom);
    return r;
  endfunction

  task send_request(req_t r);
    int gap;
    if (sender_calm > 0) begin
      sender_calm--;
      gap = 0;
    end else begin
      gap = idle_length();
      if ($urandom_range(0, 39) == 0) sender_calm = $urandom_range(15, 60);
    end
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= r;
    do @(posedge clk); while (!in_ready);
    board.note_request(r);
  endtask

  task wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (board.pending() != 0) @(negedge clk);
  endtask

  task write_capacity(logic [15:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    board.capacity = value;
  endtask

  // Result side: random stalls, calm stretches, and a long hold-off on demand.
  initial begin
    int stall_left;
    int calm_left;
    stall_left = 0;
    calm_left = 0;
    forever begin
      @(negedge clk);
      if (receiver_hold > 0) begin
        out_ready <= 1'b0;
        receiver_hold--;
      end else if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
        if (calm_left > 0) calm_left--;
        else if ($urandom_range(0, 39) == 0) calm_left = $urandom_range(20, 80);
        else stall_left = idle_length();
      end
      @(posedge clk);
      if (!rst && out_valid && out_ready) board.check_result(out_data);
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("simulation failed");
    $finish;
  end

  initial begin
    logic [15:0] cap_value;
    board = new();
    for (int k = 0; k < 4; k++) begin
      pool_vendor[k] = 16'($urandom_range(1, 65535));
      pool_product[k] = 16'($urandom);
      pool_hash[k] = $urandom | 32'd1;
    end
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_request(build_request(OP_SELECT, 0, 16'd0, 16'd0, 32'd0, 16'd0));
    send_request(build_request(OP_RESELECT, 0, 16'd0, 16'd0, 32'd0, 16'd0));
    send_request(build_request(OP_WRITE, 0, pool_vendor[0], pool_product[0], pool_hash[0],
                               16'd0));
    send_request(build_request(OP_WRITE, 15, pool_vendor[0], pool_product[0], pool_hash[1],
                               CAPACITY_RESET));
    send_request(build_request(OP_WRITE, 255, pool_vendor[0], pool_product[0], pool_hash[0],
                               16'hFFFF));
    send_request(build_request(OP_WRITE, 16, pool_vendor[0], pool_product[0], pool_hash[0],
                               16'd0));
    send_request(build_request(OP_WRITE, 3, pool_vendor[0], pool_product[0], pool_hash[0],
                               CAPACITY_RESET + 16'd1));
    send_request(build_request(OP_SELECT, 0, pool_vendor[0], pool_product[0], pool_hash[1],
                               16'd0));
    send_request(build_request(OP_SELECT, 0, pool_vendor[0], pool_product[0], pool_hash[1],
                               16'd0));
    send_request(build_request(OP_SELECT, 0, pool_vendor[0], pool_product[0], 32'd0, 16'd0));
    send_request(build_request(OP_SELECT, 0, pool_vendor[0], pool_product[0], pool_hash[2],
                               16'd0));
    send_request(build_request(OP_WRITE, 0, pool_vendor[1], pool_product[1], pool_hash[0],
                               16'd5));
    send_request(build_request(OP_ERASE, 15, 16'd0, 16'd0, 32'd0, 16'd0));
    send_request(build_request(OP_RESELECT, 0, 16'd0, 16'd0, 32'd0, 16'd0));
    send_request(build_request(OP_ERASE, 200, 16'd0, 16'd0, 32'd0, 16'd0));
    send_request(build_request(OP_ERASE, 255, 16'hFFFF, 16'hFFFF, 32'hFFFFFFFF, 16'hFFFF));
    send_request(build_request(OP_WRITE, 7, 16'hFFFF, 16'hFFFF, 32'hFFFFFFFF, 16'd1));
    send_request(build_request(OP_SELECT, 0, 16'hFFFF, 16'hFFFF, 32'd0, 16'd0));
    send_request(build_request(OP_RESELECT, 0, 16'd0, 16'd0, 32'd0, 16'd0));
    send_request(build_request(OP_WRITE, 9, 16'd0, 16'd0, 32'd5, 16'd0));
    send_request(build_request(OP_SELECT, 0, 16'd0, 16'd0, 32'd5, 16'd0));
    send_request(build_request(OP_ERASE, 7, 16'd0, 16'd0, 32'd0, 16'd0));
    send_request(build_request(OP_ERASE, 0, 16'd0, 16'd0, 32'd0, 16'd0));
    wait_drained();

    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: cap_value = 16'd0;
        1: cap_value = 16'hFFFF;
        3: cap_value = 16'd1;
        5: cap_value = CAPACITY_RESET;
        default: cap_value = 16'($urandom_range(0, 12000));
      endcase
      write_capacity(cap_value);
      if (phase == 1) begin
        for (int s = 0; s < DIRECTORY_SLOTS; s++)
          send_request(build_request(OP_WRITE, s, pool_vendor[s % 4], pool_product[s % 4],
                                     $urandom, 16'($urandom)));
      end
      for (int n = 0; n < PHASE_REQUESTS; n++) begin
        if (phase == 2 && n == 10) receiver_hold = 300;
        send_request(random_request());
      end
      wait_drained();
    end

    repeat (2 * DIRECTORY_SLOTS + 8) @(posedge clk);
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+src
src/ksdl_pkg.sv
src/ksdl_ram.sv
src/keyed_slot_directory_lookup.sv
test/ksdl_directory_check_pkg.sv
test/keyed_slot_directory_lookup_test.sv
